// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the LCD write sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/lcdseq_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Types and constants shared by the LCD nibble write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdseq_pkg;

   localparam int REQ_W       = 2;
   localparam int ADDR_W      = 5;
   localparam int CHAR_W      = 8;
   localparam int NIB_W       = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int STORE_DEPTH = 32;
   localparam int INIT_COUNT  = 5;

   localparam logic [CHAR_W-1:0] CMD_JUMP = 8'hC0;
   localparam logic [CHAR_W-1:0] CMD_HOME = 8'h03;

   // reset values of the configuration registers
   localparam logic [CHAR_W-1:0] DELAY_RESET = 8'd50;
   localparam logic [CHAR_W-1:0] INIT_RESET [INIT_COUNT] =
      '{8'h33, 8'h32, 8'h28, 8'h08, 8'h01};

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK   = 2'd0,
      REQ_INIT   = 2'd1,
      REQ_UPDATE = 2'd2,
      REQ_WRITE  = 2'd3
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY = 3'd0,
      CSR_INIT0 = 3'd1,
      CSR_INIT1 = 3'd2,
      CSR_INIT2 = 3'd3,
      CSR_INIT3 = 3'd4,
      CSR_INIT4 = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_HIGH  = 3'd0,
      ST_EDOWN = 3'd1,
      ST_WAIT  = 3'd2,
      ST_LOW   = 3'd3,
      ST_CHECK = 3'd4,
      ST_IDLE  = 3'd5
   } step_state_type;

   // what the pin stage does with the pin levels for one transfer
   typedef enum logic [2:0] {
      PIN_KEEP   = 3'd0,
      PIN_HIGH   = 3'd1,
      PIN_EDOWN  = 3'd2,
      PIN_LOW    = 3'd3,
      PIN_CMDLOW = 3'd4
   } pin_op_type;

   typedef struct packed {
      pin_op_type        op;
      logic              use_mem;
      logic [CHAR_W-1:0] const_byte;
      logic              rs;
      logic              busy;
   } pin_cmd_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } store_access_type;

endpackage

`default_nettype wire

// ===== hdl/lcdseq_ifs.sv =====
// ----------------------------------------------------------------------------
// lcdseq_req_if / lcdseq_rsp_if
// Valid/ready channels for requests and pin results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdseq_req_if import lcdseq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [ADDR_W-1:0] char_addr;
   logic [CHAR_W-1:0] char_data;

   modport source (output valid, output req_type, output char_addr, output char_data,
                   input ready);
   modport sink   (input valid, input req_type, input char_addr, input char_data,
                   output ready);
endinterface

interface lcdseq_rsp_if import lcdseq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [NIB_W-1:0] data_nibble;
   logic             enable_line;
   logic             reg_select;
   logic             busy_res;

   modport source (output valid, output data_nibble, output enable_line,
                   output reg_select, output busy_res, input ready);
   modport sink   (input valid, input data_nibble, input enable_line,
                   input reg_select, input busy_res, output ready);
endinterface

`default_nettype wire

// ===== hdl/char_lcd_nibble_write_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_unit
// 4-bit character LCD write sequencer: init and message update sequences,
// one sequencer step per tick, message kept in a 32-byte store.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                         | handshake
//  req_bus | in  | req_type, char_addr, char_data                 | valid/ready
//  rsp_bus | out | data_nibble, enable_line, reg_select, busy_res  | valid/ready
//  csr_*   | in  | csr_index, csr_wdata                           | csr_we
//
//  One request per clock while req_bus.ready is high; step logic and store read
//  register it at the transfer edge, the pin register when the pin stage moves.
//  The store read port is read once per request; a write lands before any
//  later read, so no forwarding path exists.
//  Reset is synchronous; the store is not cleared and has no clearing pass.
//  A stalled result holds one request in the pin stage, then req_bus.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_write_sequencer_unit import lcdseq_pkg::*; #(
   parameter int ROW_CHARS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   lcdseq_req_if.sink                req_bus,
   lcdseq_rsp_if.source              rsp_bus,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CHAR_W-1:0]    csr_wdata
);

   logic              acc;
   logic              in_ready;
   store_access_type  store_acc;
   pin_cmd_type       pin_cmd;
   logic [CHAR_W-1:0] rd_data;

   // request transfer
   assign req_bus.ready = in_ready;
   assign acc           = req_bus.valid && in_ready;

   lcdseq_ctrl #(
      .ROW_CHARS (ROW_CHARS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .acc       (acc),
      .req_type  (req_bus.req_type),
      .char_addr (req_bus.char_addr),
      .char_data (req_bus.char_data),
      .store_acc (store_acc),
      .pin_cmd   (pin_cmd)
   );

   lcdseq_store u_store (
      .clock   (clock),
      .acc_in  (store_acc),
      .rd_data (rd_data)
   );

   lcdseq_pins u_pins (
      .clock    (clock),
      .reset    (reset),
      .acc      (acc),
      .cmd_in   (pin_cmd),
      .rd_data  (rd_data),
      .in_ready (in_ready),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== hdl/lcdseq_store.sv =====
// ----------------------------------------------------------------------------
// lcdseq_store
// 32 x 8 message store, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_store import lcdseq_pkg::*; (
   input  wire logic              clock,
   input  wire store_access_type  acc_in,
   output      logic [CHAR_W-1:0] rd_data
);

   logic [CHAR_W-1:0] mem [STORE_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (acc_in.wr_en) begin
         mem[acc_in.wr_addr] <= acc_in.wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (acc_in.rd_en) begin
         rd_data_ff <= mem[acc_in.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/lcdseq_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcdseq_ctrl
// Sequencer step logic and configuration registers; issues store accesses
// and a pin command for every accepted request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lcdseq_ctrl import lcdseq_pkg::*; #(
   parameter int ROW_CHARS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CHAR_W-1:0]    csr_wdata,
   input  wire logic                 acc,
   input  wire logic [REQ_W-1:0]     req_type,
   input  wire logic [ADDR_W-1:0]    char_addr,
   input  wire logic [CHAR_W-1:0]    char_data,
   output      store_access_type     store_acc,
   output      pin_cmd_type          pin_cmd
);

   // byte counters hold a full row and the init count
   localparam int IDX_W = ($clog2(ROW_CHARS + 1) > 3) ? $clog2(ROW_CHARS + 1) : 3;
   localparam int SUM_W = IDX_W + ADDR_W;

   logic [CHAR_W-1:0] delay_ff;
   logic [CHAR_W-1:0] init_cmd_ff [INIT_COUNT];

   step_state_type    step_ff, step_in;
   step_state_type    ret_ff, ret_in;
   logic [CHAR_W-1:0] wait_ff, wait_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  total_ff, total_in;
   logic              second_ff, second_in;
   logic              dmode_ff, dmode_in;
   logic              jump_ff, jump_in;
   logic              row_ff, row_in;

   logic              more_bytes;
   logic [SUM_W-1:0]  store_pos;
   req_code_type      req_code;

   assign req_code   = req_code_type'(req_type);
   assign more_bytes = idx_ff < total_ff;
   assign store_pos  = (row_ff ? SUM_W'(ROW_CHARS) : '0) + SUM_W'(idx_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
         for (int i = 0; i < INIT_COUNT; i++) begin
            init_cmd_ff[i] <= INIT_RESET[i];
         end
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DELAY: delay_ff       <= csr_wdata;
            CSR_INIT0: init_cmd_ff[0] <= csr_wdata;
            CSR_INIT1: init_cmd_ff[1] <= csr_wdata;
            CSR_INIT2: init_cmd_ff[2] <= csr_wdata;
            CSR_INIT3: init_cmd_ff[3] <= csr_wdata;
            CSR_INIT4: init_cmd_ff[4] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state of the sequencer
   always_comb begin
      step_in   = step_ff;
      ret_in    = ret_ff;
      wait_in   = wait_ff;
      idx_in    = idx_ff;
      total_in  = total_ff;
      second_in = second_ff;
      dmode_in  = dmode_ff;
      jump_in   = jump_ff;
      row_in    = row_ff;
      case (req_code)
         REQ_TICK: begin
            case (step_ff)
               ST_HIGH: begin
                  step_in = ST_WAIT;
                  ret_in  = ST_EDOWN;
               end
               ST_EDOWN: begin
                  step_in   = ST_WAIT;
                  ret_in    = second_ff ? ST_CHECK : ST_LOW;
                  second_in = ~second_ff;
               end
               ST_WAIT: begin
                  if (wait_ff == '0) begin
                     wait_in = delay_ff;
                     step_in = ret_ff;
                  end else begin
                     wait_in = wait_ff - CHAR_W'(1);
                  end
               end
               ST_LOW: begin
                  step_in = ST_WAIT;
                  ret_in  = ST_EDOWN;
                  idx_in  = idx_ff + IDX_W'(1);
               end
               ST_CHECK: begin
                  if (more_bytes) begin
                     step_in = ST_WAIT;
                     ret_in  = ST_HIGH;
                  end else begin
                     idx_in  = '0;
                     step_in = ST_IDLE;
                     if (dmode_ff) begin
                        if (!jump_ff) begin
                           // row done: cursor jump or home command next
                           jump_in  = 1'b1;
                           total_in = IDX_W'(1);
                           step_in  = ST_WAIT;
                           ret_in   = ST_HIGH;
                        end else if (!row_ff) begin
                           jump_in  = 1'b0;
                           row_in   = 1'b1;
                           total_in = IDX_W'(ROW_CHARS);
                           step_in  = ST_HIGH;
                        end else begin
                           jump_in = 1'b0;
                           row_in  = 1'b0;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
         REQ_INIT, REQ_UPDATE: begin
            // starts are dropped while a sequence runs
            if (step_ff == ST_IDLE) begin
               idx_in    = '0;
               second_in = 1'b0;
               jump_in   = 1'b0;
               row_in    = 1'b0;
               step_in   = ST_HIGH;
               if (req_code == REQ_INIT) begin
                  dmode_in = 1'b0;
                  total_in = IDX_W'(INIT_COUNT);
               end else begin
                  dmode_in = 1'b1;
                  total_in = IDX_W'(ROW_CHARS);
               end
            end
         end
         default: ;
      endcase
   end

   // sequencer registers, advanced once per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= ST_IDLE;
         ret_ff    <= ST_HIGH;
         wait_ff   <= DELAY_RESET;
         idx_ff    <= '0;
         total_ff  <= '0;
         second_ff <= 1'b0;
         dmode_ff  <= 1'b0;
         jump_ff   <= 1'b0;
         row_ff    <= 1'b0;
      end else if (acc) begin
         step_ff   <= step_in;
         ret_ff    <= ret_in;
         wait_ff   <= wait_in;
         idx_ff    <= idx_in;
         total_ff  <= total_in;
         second_ff <= second_in;
         dmode_ff  <= dmode_in;
         jump_ff   <= jump_in;
         row_ff    <= row_in;
      end
   end

   // store accesses and pin command
   always_comb begin
      store_acc.wr_en   = acc && (req_code == REQ_WRITE);
      store_acc.wr_addr = char_addr;
      store_acc.wr_data = char_data;
      store_acc.rd_en   = acc;
      store_acc.rd_addr = store_pos[ADDR_W-1:0];

      pin_cmd.use_mem = dmode_ff && !jump_ff;
      pin_cmd.rs      = dmode_ff && !jump_ff;
      pin_cmd.busy    = step_in != ST_IDLE;
      if (!dmode_ff) begin
         pin_cmd.const_byte = (idx_ff < IDX_W'(INIT_COUNT)) ? init_cmd_ff[idx_ff[2:0]] : '0;
      end else begin
         pin_cmd.const_byte = row_ff ? CMD_HOME : CMD_JUMP;
      end

      pin_cmd.op = PIN_KEEP;
      if (req_code == REQ_TICK) begin
         case (step_ff)
            ST_HIGH:  pin_cmd.op = PIN_HIGH;
            ST_EDOWN: pin_cmd.op = PIN_EDOWN;
            ST_LOW:   pin_cmd.op = PIN_LOW;
            ST_CHECK: begin
               if (!more_bytes && dmode_ff && !jump_ff) begin
                  pin_cmd.op = PIN_CMDLOW;
               end
            end
            default:  pin_cmd.op = PIN_KEEP;
         endcase
      end
   end

   `ASSERT_ALWAYS(a_idx_in_range, clock, reset, idx_ff <= total_ff, "byte index past total")
   `ASSERT_IMPL(a_jump_data, clock, reset, jump_ff, dmode_ff, "jump phase outside update")
   `ASSERT_IMPL(a_row_data, clock, reset, row_ff, dmode_ff, "second row outside update")
   `ASSERT_NEXT(a_idle_start, clock, reset,
      acc && (step_ff == ST_IDLE) && (req_code == REQ_INIT || req_code == REQ_UPDATE),
      step_ff == ST_HIGH && idx_ff == '0, "start did not load the high nibble step")

endmodule

`default_nettype wire

// ===== hdl/lcdseq_pins.sv =====
// ----------------------------------------------------------------------------
// lcdseq_pins
// Pin stage: joins store read data with the pin command, holds the pin
// levels and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lcdseq_pins import lcdseq_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              acc,
   input  wire pin_cmd_type       cmd_in,
   input  wire logic [CHAR_W-1:0] rd_data,
   output      logic              in_ready,
   lcdseq_rsp_if.source           rsp_bus
);

   logic              b_valid_ff, b_valid_in;
   pin_cmd_type       b_cmd_ff;
   logic              b_move;

   logic              o_valid_ff, o_valid_in;
   logic [NIB_W-1:0]  nib_ff, nib_in;
   logic              en_ff, en_in;
   logic              rs_ff, rs_in;
   logic              busy_ff;
   logic [CHAR_W-1:0] cur_byte;

   // stage handshake
   assign b_move     = b_valid_ff && (!o_valid_ff || rsp_bus.ready);
   assign in_ready   = !b_valid_ff || b_move;
   assign b_valid_in = acc ? 1'b1 : (b_move ? 1'b0 : b_valid_ff);
   assign o_valid_in = b_move ? 1'b1 : (rsp_bus.ready ? 1'b0 : o_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         b_cmd_ff <= cmd_in;
      end
   end

   // new pin levels
   assign cur_byte = b_cmd_ff.use_mem ? rd_data : b_cmd_ff.const_byte;

   always_comb begin
      nib_in = nib_ff;
      en_in  = en_ff;
      rs_in  = rs_ff;
      case (b_cmd_ff.op)
         PIN_HIGH: begin
            nib_in = cur_byte[CHAR_W-1:NIB_W];
            en_in  = 1'b1;
            rs_in  = b_cmd_ff.rs;
         end
         PIN_EDOWN: en_in = 1'b0;
         PIN_LOW: begin
            nib_in = cur_byte[NIB_W-1:0];
            en_in  = 1'b1;
         end
         PIN_CMDLOW: begin
            en_in = 1'b0;
            rs_in = 1'b0;
         end
         default: ;
      endcase
   end

   // pin levels double as the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         nib_ff  <= '0;
         en_ff   <= 1'b0;
         rs_ff   <= 1'b0;
         busy_ff <= 1'b0;
      end else if (b_move) begin
         nib_ff  <= nib_in;
         en_ff   <= en_in;
         rs_ff   <= rs_in;
         busy_ff <= b_cmd_ff.busy;
      end
   end

   assign rsp_bus.valid       = o_valid_ff;
   assign rsp_bus.data_nibble = nib_ff;
   assign rsp_bus.enable_line = en_ff;
   assign rsp_bus.reg_select  = rs_ff;
   assign rsp_bus.busy_res    = busy_ff;

   `ASSERT_NEXT(a_high_strobe, clock, reset, b_move && b_cmd_ff.op == PIN_HIGH, en_ff,
      "high nibble without enable")
   `ASSERT_NEXT(a_cmd_low, clock, reset, b_move && b_cmd_ff.op == PIN_CMDLOW,
      !en_ff && !rs_ff, "command setup left enable or select high")
   `ASSERT_IMPL(a_full_stall, clock, reset, b_valid_ff && o_valid_ff && !rsp_bus.ready,
      !in_ready, "transfer taken with both stages full")

endmodule

`default_nettype wire
